FILE: src/thermal_fan_supervisor_macros.svh
// Assertion macros shared by the thermal fan supervisor RTL.
`ifndef THERMAL_FAN_SUPERVISOR_MACROS_SVH
`define THERMAL_FAN_SUPERVISOR_MACROS_SVH

`ifndef SYNTHESIS

// Check that post holds in the same cycle as pre
`define TFS_ASSERT_IMPL(name, clk, rst, pre, post) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("tfs assertion failed: same-cycle implication");

// Check that post holds in the cycle after pre
`define TFS_ASSERT_NEXT(name, clk, rst, pre, post) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("tfs assertion failed: next-cycle implication");

`else

`define TFS_ASSERT_IMPL(name, clk, rst, pre, post)
`define TFS_ASSERT_NEXT(name, clk, rst, pre, post)

`endif

`endif

FILE: src/tfs_pkg.sv
// Types and constants of the thermal fan supervisor.
package tfs_pkg;

   localparam int REQ_W      = 136;
   localparam int RSP_W      = 32;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam int HYST_W     = 10;
   localparam int TEMP_W     = 16;
   localparam int DUTY_W     = 7;
   localparam int STALL_W    = 4;

   // Register indexes of the configuration port
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_HYSTERESIS = 3'd0,
      CSR_FAN0_MIN   = 3'd1,
      CSR_FAN1_MIN   = 3'd2,
      CSR_FAN2_MIN   = 3'd3,
      CSR_FAN0_MAX   = 3'd4,
      CSR_FAN1_MAX   = 3'd5,
      CSR_FAN2_MAX   = 3'd6,
      CSR_SUPPLY_MAX = 3'd7
   } csr_index_type;

   // Buzzer modes
   typedef enum logic [1:0] {
      BUZ_OFF   = 2'd0,
      BUZ_ON    = 2'd1,
      BUZ_SHORT = 2'd2
   } buzzer_type;

   // Register reset values
   localparam logic [HYST_W-1:0] HYST_RESET       = 10'd20;
   localparam logic [TEMP_W-1:0] FAN0_MIN_RESET   = 16'd300;
   localparam logic [TEMP_W-1:0] FAN1_MIN_RESET   = 16'd300;
   localparam logic [TEMP_W-1:0] FAN2_MIN_RESET   = 16'd300;
   localparam logic [TEMP_W-1:0] FAN0_MAX_RESET   = 16'd600;
   localparam logic [TEMP_W-1:0] FAN1_MAX_RESET   = 16'd500;
   localparam logic [TEMP_W-1:0] FAN2_MAX_RESET   = 16'd500;
   localparam logic [TEMP_W-1:0] SUPPLY_MAX_RESET = 16'd800;

   // Ramp shape: fans 0 and 1 use the main ramp, fan 2 the auxiliary one
   localparam logic [DUTY_W-1:0] DUTY_FULL      = 7'd100;
   localparam logic [DUTY_W-1:0] DUTY_ZERO      = 7'd0;
   localparam logic [DUTY_W-1:0] RAMP_SPAN_MAIN = 7'd80;
   localparam logic [DUTY_W-1:0] RAMP_BASE_MAIN = 7'd20;
   localparam logic [DUTY_W-1:0] RAMP_SPAN_AUX  = 7'd60;
   localparam logic [DUTY_W-1:0] RAMP_BASE_AUX  = 7'd40;

   // Fan index of the last fan, which has no tach and no switch
   localparam logic [1:0] FAN_LAST = 2'd2;
   // Index of the supply source in the critical flags
   localparam logic [1:0] SRC_SUPPLY = 2'd3;

   // Request word, first field in the lowest bits
   typedef struct packed {
      logic [5:0]               pad;
      logic [31:0]              now_ms;
      logic                     power_off_button;
      logic                     power_on_button;
      logic [15:0]              tach_fan1;
      logic [15:0]              tach_fan0;
      logic signed [TEMP_W-1:0] temp_supply;
      logic signed [TEMP_W-1:0] temp_inner;
      logic signed [TEMP_W-1:0] temp_disk;
      logic signed [TEMP_W-1:0] temp_cpu;
   } req_word_type;

   // Response word, first field in the lowest bits
   typedef struct packed {
      logic [1:0]        pad;
      logic              monitor_disabled;
      logic              fan1_dead;
      logic              fan0_dead;
      logic              shutdown_pending;
      logic [1:0]        buzzer_mode;
      logic              fan1_enable_out;
      logic              fan0_enable_out;
      logic              relay_out;
      logic [DUTY_W-1:0] duty_fan2;
      logic [DUTY_W-1:0] duty_fan1;
      logic [DUTY_W-1:0] duty_fan0;
   } rsp_word_type;

endpackage

FILE: src/thermal_fan_supervisor.sv
// Thermal fan supervisor: one monitoring word in, one control word out.
// Sequence: when halted, the word goes straight from the button step to the response;
//   else each fan inside its ramp band also runs the shared 7-step ramp divider.
// Flow: the request side waits until the sequencer is back in idle, and a waiting
//   response holds the final step.
// Reset: synchronous, active high; clears all control state and loads register defaults.
`include "thermal_fan_supervisor_macros.svh"

module thermal_fan_supervisor #(
   parameter int unsigned SHUTDOWN_DELAY_MS = 5000,
   parameter int unsigned BUTTON_HOLDOFF_MS = 5000,
   parameter int unsigned STALL_LIMIT       = 10
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // temp_cpu, temp_disk, temp_inner, temp_supply, tach_fan0, tach_fan1,
   // power_on_button, power_off_button, now_ms, zero pad
   input  logic [tfs_pkg::REQ_W-1:0]      req_tdata,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // duty_fan0, duty_fan1, duty_fan2, relay_out, fan0_enable_out, fan1_enable_out,
   // buzzer_mode, shutdown_pending, fan0_dead, fan1_dead, monitor_disabled, zero pad
   output logic [tfs_pkg::RSP_W-1:0]      rsp_tdata,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [tfs_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [tfs_pkg::CSR_DATA_W-1:0] csr_data
);
   import tfs_pkg::*;

   localparam logic [31:0]        DELAY   = 32'(SHUTDOWN_DELAY_MS);
   localparam logic [31:0]        HOLDOFF = 32'(BUTTON_HOLDOFF_MS);
   localparam logic [STALL_W-1:0] STALL_LIM = STALL_W'(STALL_LIMIT);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_BUTTON,
      ST_EVAL,
      ST_DIVIDE,
      ST_RAMP,
      ST_SUPPLY,
      ST_EXPIRE,
      ST_DONE
   } state_type;

   // Configuration registers
   logic [HYST_W-1:0]               hyst_ff;
   logic [2:0][TEMP_W-1:0]          min_ff;
   logic [2:0][TEMP_W-1:0]          max_ff;
   logic [TEMP_W-1:0]               supply_max_ff;

   // Sequencer and supervisor state
   state_type                       state_ff, state_in;
   logic [1:0]                      fan_ff, fan_in;
   req_word_type                    item_ff, item_in;
   logic [31:0]                     deadline_ff, deadline_in;
   logic [31:0]                     press_ff, press_in;
   logic [1:0][STALL_W-1:0]         stall_ff, stall_in;
   logic [3:0]                      crit_ff, crit_in;
   logic                            halted_ff, halted_in;
   logic [2:0][DUTY_W-1:0]          duty_ff, duty_in;
   logic                            relay_ff, relay_in;
   logic [1:0]                      switch_ff, switch_in;
   buzzer_type                      buzzer_ff, buzzer_in;

   // Ramp divider
   logic [22:0]                     rem_ff, rem_in;
   logic [21:0]                     dsr_ff, dsr_in;
   logic [DUTY_W-1:0]               quot_ff, quot_in;
   logic [2:0]                      step_ff, step_in;

   // Response register
   logic                            rsp_valid_ff, rsp_valid_in;
   rsp_word_type                    rsp_ff, rsp_in;

   // Per-fan selection and compare
   logic signed [TEMP_W-1:0]        t_sel, lo_sel, hi_sel;
   logic [15:0]                     tach_sel;
   logic [DUTY_W-1:0]               span_sel, base_sel;
   logic signed [17:0]              t_ext, low_lim, high_lim;
   logic                            below, above, in_ramp;
   logic [16:0]                     t_minus_lo, hi_minus_lo;
   logic [22:0]                     numer;
   logic [31:0]                     arm_sum, arm_value;
   logic                            div_ge;
   logic [DUTY_W:0]                 ramp_sum;
   logic                            fidx;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_ff;
   assign csr_ready  = 1'b1;

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         hyst_ff       <= HYST_RESET;
         min_ff[0]     <= FAN0_MIN_RESET;
         min_ff[1]     <= FAN1_MIN_RESET;
         min_ff[2]     <= FAN2_MIN_RESET;
         max_ff[0]     <= FAN0_MAX_RESET;
         max_ff[1]     <= FAN1_MAX_RESET;
         max_ff[2]     <= FAN2_MAX_RESET;
         supply_max_ff <= SUPPLY_MAX_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_HYSTERESIS: hyst_ff       <= csr_data[HYST_W-1:0];
            CSR_FAN0_MIN:   min_ff[0]     <= csr_data;
            CSR_FAN1_MIN:   min_ff[1]     <= csr_data;
            CSR_FAN2_MIN:   min_ff[2]     <= csr_data;
            CSR_FAN0_MAX:   max_ff[0]     <= csr_data;
            CSR_FAN1_MAX:   max_ff[1]     <= csr_data;
            CSR_FAN2_MAX:   max_ff[2]     <= csr_data;
            CSR_SUPPLY_MAX: supply_max_ff <= csr_data;
            default:        hyst_ff       <= hyst_ff;
         endcase
      end
   end

   // Select the sensor, thresholds and ramp shape of the current fan
   always_comb begin
      fidx = fan_ff[0];
      case (fan_ff)
         2'd0: begin
            t_sel    = item_ff.temp_cpu;
            tach_sel = item_ff.tach_fan0;
         end
         2'd1: begin
            t_sel    = item_ff.temp_disk;
            tach_sel = item_ff.tach_fan1;
         end
         default: begin
            t_sel    = item_ff.temp_inner;
            tach_sel = item_ff.tach_fan0;
         end
      endcase
      lo_sel   = $signed(min_ff[fan_ff]);
      hi_sel   = $signed(max_ff[fan_ff]);
      span_sel = (fan_ff == FAN_LAST) ? RAMP_SPAN_AUX : RAMP_SPAN_MAIN;
      base_sel = (fan_ff == FAN_LAST) ? RAMP_BASE_AUX : RAMP_BASE_MAIN;

      // Thresholds at full precision
      t_ext    = {{2{t_sel[15]}}, t_sel};
      low_lim  = {{2{lo_sel[15]}}, lo_sel} - {8'd0, hyst_ff};
      high_lim = {{2{hi_sel[15]}}, hi_sel} + {8'd0, hyst_ff};
      below    = t_ext < low_lim;
      above    = t_ext > high_lim;
      in_ramp  = (t_sel > lo_sel) && (t_sel < hi_sel);

      // Both differences are positive inside the ramp band
      t_minus_lo  = {t_sel[15], t_sel} - {lo_sel[15], lo_sel};
      hi_minus_lo = {hi_sel[15], hi_sel} - {lo_sel[15], lo_sel};
      numer       = {16'd0, span_sel} * {7'd0, t_minus_lo[15:0]};

      // Shutdown deadline, zero stands for not armed
      arm_sum   = item_ff.now_ms + DELAY;
      arm_value = (arm_sum == 32'd0) ? 32'd1 : arm_sum;

      div_ge   = rem_ff >= {1'b0, dsr_ff};
      ramp_sum = {1'b0, base_sel} + {1'b0, quot_ff};
   end

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      fan_in       = fan_ff;
      item_in      = item_ff;
      deadline_in  = deadline_ff;
      press_in     = press_ff;
      stall_in     = stall_ff;
      crit_in      = crit_ff;
      halted_in    = halted_ff;
      duty_in      = duty_ff;
      relay_in     = relay_ff;
      switch_in    = switch_ff;
      buzzer_in    = buzzer_ff;
      rem_in       = rem_ff;
      dsr_in       = dsr_ff;
      quot_in      = quot_ff;
      step_in      = step_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               item_in  = req_word_type'(req_tdata);
               state_in = ST_BUTTON;
            end
         end

         // Handle the power-on and all-off buttons
         ST_BUTTON: begin
            if (item_ff.power_on_button) begin
               relay_in  = 1'b1;
               halted_in = 1'b0;
            end
            if (item_ff.power_off_button) begin
               if (!(press_ff != 32'd0 && (item_ff.now_ms - press_ff) < HOLDOFF)) begin
                  press_in  = (item_ff.now_ms == 32'd0) ? 32'd1 : item_ff.now_ms;
                  buzzer_in = BUZ_OFF;
                  duty_in   = '0;
                  relay_in  = 1'b0;
                  halted_in = 1'b1;
               end
            end else begin
               press_in = 32'd0;
            end
            fan_in   = 2'd0;
            state_in = halted_in ? ST_DONE : ST_EVAL;
         end

         // Classify one fan's temperature and, for fans 0 and 1, run its stall check
         ST_EVAL: begin
            state_in = (fan_ff == FAN_LAST) ? ST_SUPPLY : ST_EVAL;
            fan_in   = fan_ff + 2'd1;
            if (below) begin
               duty_in[fan_ff] = DUTY_ZERO;
            end else if (above) begin
               if (deadline_ff == 32'd0) begin
                  crit_in[fan_ff] = 1'b1;
                  deadline_in     = arm_value;
                  buzzer_in       = BUZ_ON;
                  duty_in[fan_ff] = DUTY_FULL;
               end
            end else begin
               crit_in[fan_ff] = 1'b0;
               if (fan_ff != FAN_LAST) begin
                  if (switch_ff[fidx]) begin
                     if (duty_ff[fan_ff] != DUTY_ZERO && tach_sel == 16'd0) begin
                        if (stall_ff[fidx] > STALL_LIM) begin
                           buzzer_in = BUZ_SHORT;
                        end else begin
                           stall_in[fidx] = STALL_W'(stall_ff[fidx] + 1'b1);
                        end
                     end else if (stall_ff[fidx] != '0) begin
                        buzzer_in      = BUZ_OFF;
                        stall_in[fidx] = '0;
                     end
                  end else begin
                     switch_in[fidx] = 1'b1;
                  end
               end
               // Start the ramp division; the quotient stays below the span
               if (in_ramp) begin
                  rem_in   = numer;
                  dsr_in   = {hi_minus_lo[15:0], 6'd0};
                  quot_in  = '0;
                  step_in  = 3'd6;
                  fan_in   = fan_ff;
                  state_in = ST_DIVIDE;
               end
            end
         end

         // One quotient bit per cycle
         ST_DIVIDE: begin
            if (div_ge) begin
               rem_in = rem_ff - {1'b0, dsr_ff};
            end
            quot_in = {quot_ff[DUTY_W-2:0], div_ge};
            dsr_in  = dsr_ff >> 1;
            step_in = step_ff - 3'd1;
            if (step_ff == 3'd0) begin
               state_in = ST_RAMP;
            end
         end

         // Add the base and clamp to full duty
         ST_RAMP: begin
            duty_in[fan_ff] = (ramp_sum > {1'b0, DUTY_FULL}) ? DUTY_FULL
                                                             : ramp_sum[DUTY_W-1:0];
            fan_in   = fan_ff + 2'd1;
            state_in = (fan_ff == FAN_LAST) ? ST_SUPPLY : ST_EVAL;
         end

         // Supply over-temperature forces all fans on at full duty
         ST_SUPPLY: begin
            if (item_ff.temp_supply > $signed(supply_max_ff)) begin
               duty_in   = {DUTY_FULL, DUTY_FULL, DUTY_FULL};
               switch_in = 2'b11;
               if (deadline_ff == 32'd0) begin
                  crit_in[SRC_SUPPLY] = 1'b1;
                  deadline_in         = arm_value;
                  buzzer_in           = BUZ_ON;
               end
            end else begin
               crit_in[SRC_SUPPLY] = 1'b0;
            end
            state_in = ST_EXPIRE;
         end

         // Cancel or fire an armed shutdown
         ST_EXPIRE: begin
            if (deadline_ff != 32'd0) begin
               if (crit_ff == 4'd0) begin
                  deadline_in = 32'd0;
                  buzzer_in   = BUZ_OFF;
               end else if (item_ff.now_ms > deadline_ff) begin
                  deadline_in = 32'd0;
                  relay_in    = 1'b0;
                  buzzer_in   = BUZ_OFF;
               end
            end
            state_in = ST_DONE;
         end

         // Load the response word once the output register is free
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_in.pad              = '0;
               rsp_in.monitor_disabled = halted_ff;
               rsp_in.fan1_dead        = stall_ff[1] > STALL_LIM;
               rsp_in.fan0_dead        = stall_ff[0] > STALL_LIM;
               rsp_in.shutdown_pending = deadline_ff != 32'd0;
               rsp_in.buzzer_mode      = buzzer_ff;
               rsp_in.fan1_enable_out  = switch_ff[1];
               rsp_in.fan0_enable_out  = switch_ff[0];
               rsp_in.relay_out        = relay_ff;
               rsp_in.duty_fan2        = duty_ff[2];
               rsp_in.duty_fan1        = duty_ff[1];
               rsp_in.duty_fan0        = duty_ff[0];
               rsp_valid_in            = 1'b1;
               state_in                = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold state and the response register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fan_ff       <= '0;
         deadline_ff  <= '0;
         press_ff     <= '0;
         stall_ff     <= '0;
         crit_ff      <= '0;
         halted_ff    <= 1'b0;
         duty_ff      <= '0;
         relay_ff     <= 1'b0;
         switch_ff    <= '0;
         buzzer_ff    <= BUZ_OFF;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fan_ff       <= fan_in;
         deadline_ff  <= deadline_in;
         press_ff     <= press_in;
         stall_ff     <= stall_in;
         crit_ff      <= crit_in;
         halted_ff    <= halted_in;
         duty_ff      <= duty_in;
         relay_ff     <= relay_in;
         switch_ff    <= switch_in;
         buzzer_ff    <= buzzer_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      item_ff <= item_in;
      rem_ff  <= rem_in;
      dsr_ff  <= dsr_in;
      quot_ff <= quot_in;
      rsp_ff  <= rsp_in;
   end

   // The ramp quotient never reaches the span of its fan
   `TFS_ASSERT_IMPL(a_quot_below_span, clock, reset, state_ff == ST_RAMP, quot_ff < span_sel)
   // An accepted word keeps the request side closed in the next cycle
   `TFS_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_tvalid && req_tready, !req_tready)
   // Every reported duty is within range
   `TFS_ASSERT_IMPL(a_duty_range, clock, reset, rsp_valid_ff, rsp_ff.duty_fan0 <= DUTY_FULL && rsp_ff.duty_fan1 <= DUTY_FULL && rsp_ff.duty_fan2 <= DUTY_FULL)

endmodule
